// ===== hw/rtl/sha256_pkg.sv =====
// Package for the SHA-256 stream hasher: operation codes, round constants,
// initial hash values and the compression helper functions. No dependencies.
`default_nettype none
package sha256_pkg;

  localparam logic [1:0] OP_ABSORB  = 2'd0;
  localparam logic [1:0] OP_FINISH  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned HashWords  = 8;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] idx);
    logic [31:0] h;
    case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  // Control from the sequencer to the round core
  typedef struct packed {
    logic       load;    // copy chaining words into working vars
    logic [5:0] round;
    logic       step;    // perform one round
    logic       fold;    // add working vars into chaining words
  } core_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sha256_buf.sv =====
// Block byte memory: 64 x 8 synchronous RAM with a registered read port.
// Depends on sha256_pkg.
`default_nettype none
module sha256_buf #(
  parameter int unsigned Depth = sha256_pkg::BlockBytes
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [7:0]               wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [7:0]               rd_data
);

  logic [7:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sha256_core.sv =====
// Compression round engine: 16-word schedule window, working registers a..h
// and the chaining-word memory (8 x 32, read-modify-write). Depends on sha256_pkg.
`default_nettype none
module sha256_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire sha256_pkg::core_ctl_t ctl,
  input  wire logic [31:0]           wr_word,   // message word for rounds 0..15
  input  wire logic                  init,      // restore initial hash
  input  wire logic [2:0]            hrd_addr,  // chaining read address
  output logic      [31:0]           hrd_data,  // registered
  output logic                       fold_done
);

  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [31:0] w_r [16];
  logic [31:0] hs_r [8];
  logic        folding_r;
  logic [31:0] wt, wnew, t1, t2;

  // schedule word for this round
  always_comb begin
    wnew = w_r[0] + sha256_pkg::sig0(w_r[1]) + w_r[9] + sha256_pkg::sig1(w_r[14]);
    wt   = (ctl.round < 6'd16) ? wr_word : wnew;
    t1   = h_r + sha256_pkg::bsig1(e_r) + ((e_r & f_r) ^ (~e_r & g_r))
           + sha256_pkg::round_k(ctl.round) + wt;
    t2   = sha256_pkg::bsig0(a_r) + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
  end

  // working registers and schedule window
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r <= hs_r[0]; b_r <= hs_r[1]; c_r <= hs_r[2]; d_r <= hs_r[3];
      e_r <= hs_r[4]; f_r <= hs_r[5]; g_r <= hs_r[6]; h_r <= hs_r[7];
    end else if (ctl.step) begin
      h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= wt;
    end
  end

  // chaining words: all eight updated in the fold cycle
  always_ff @(posedge clk) begin
    if (!rst_n || init) begin
      for (int i = 0; i < 8; i++) begin
        hs_r[i] <= sha256_pkg::init_h(3'(i));
      end
      folding_r <= 1'b0;
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) begin
        hs_r[i] <= hs_r[i] + ((i == 0) ? a_r : (i == 1) ? b_r : (i == 2) ? c_r :
                   (i == 3) ? d_r : (i == 4) ? e_r : (i == 5) ? f_r :
                   (i == 6) ? g_r : h_r);
      end
      folding_r <= 1'b1;
    end else begin
      folding_r <= 1'b0;
    end
  end

  assign fold_done = folding_r;

  // registered read of a chaining word
  always_ff @(posedge clk) begin
    hrd_data <= hs_r[hrd_addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sha256_stream_hasher_unit.sv =====
// SHA-256 stream hasher top level: input handshake, sequencer and result
// register. Depends on sha256_pkg, sha256_buf and sha256_core.
`default_nettype none
// One message byte per item; bytes are taken back to back, one per cycle,
// while the unit is idle and the result register is free. The 64th byte
// of a block starts a compression: a load step, 16 rounds each preceded
// by four byte-memory reads, 48 rounds on the schedule and one fold; no
// byte is taken while it runs. Finish writes the padding (64 minus the
// bytes held, one per cycle) and compresses; when 56 or more bytes are
// held a second full-block pad write and compression follow. Then the
// eight digest words are emitted, one per cycle while out_tready is high.
// A repeated finish emits the stored digest again. A byte after finish
// gives one error item. An item is only taken while the result register
// is free.
module sha256_stream_hasher_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [1:0] op, [9:2] data_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic             out_tlast,  // last
  output logic             out_tuser   // error
);

  localparam int unsigned BlockBytes = sha256_pkg::BlockBytes;
  localparam int AW = $clog2(BlockBytes);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PADB  = 4'd1;  // write padding bytes to memory
  localparam logic [3:0] S_LOAD  = 4'd2;  // load working vars, prime read
  localparam logic [3:0] S_FETCH = 4'd3;  // gather 4 bytes into a word
  localparam logic [3:0] S_RND   = 4'd4;  // round with fetched word
  localparam logic [3:0] S_RNDX  = 4'd5;  // rounds 16..63
  localparam logic [3:0] S_FOLD  = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;

  logic [3:0]    st_r, st_nxt;
  logic [AW-1:0] fill_r;
  logic [63:0]   bits_r;
  logic          fin_r;
  logic          pad_r;      // padding in progress
  logic          second_r;   // a second pad block is needed
  logic [6:0]    padp_r;     // padding write position
  logic [5:0]    rnd_r;
  logic [1:0]    bsel_r;
  logic [31:0]   word_r;
  logic [AW-1:0] rda_r;
  logic [3:0]    eidx_r;
  logic          ovalid_r, olast_r, oerr_r;
  logic [31:0]   oword_r;
  logic [2:0]    oidx_r;

  logic [1:0] op;
  logic [7:0] dbyte;
  assign op    = in_tdata[1:0];
  assign dbyte = in_tdata[9:2];

  logic        acc;
  logic        out_free;
  assign out_free  = !ovalid_r || out_tready;
  assign in_tready = (st_r == S_IDLE) && out_free;
  assign acc       = in_tvalid && in_tready;

  // memory signals
  logic          bwe;
  logic [AW-1:0] bwa;
  logic [7:0]    bwd, brd;
  logic [31:0]   hrd;
  logic          fdone;
  sha256_pkg::core_ctl_t ctl;

  // padding byte at position padp_r (fill_r .. 63 of the current pad block)
  logic [7:0] padbyte;
  logic [6:0] lenpos;
  always_comb begin
    lenpos  = padp_r - 7'd56;
    padbyte = 8'h00;
    if (padp_r[5:0] == fill_r && !second_r && padp_r < 7'd64 && pad_r)
      padbyte = 8'h00;
    if (padp_r >= 7'd56 && padp_r < 7'd64 && !(second_r && !pad_r))
      padbyte = 8'(bits_r >> (7'd56 - 7'(8 * lenpos[2:0])));
  end

  // sequencer
  logic          do_absorb, do_fin;
  logic          first_pad_r; // 0x80 still to be placed
  logic          len_here_r;  // length goes in this pad block
  always_comb begin
    st_nxt    = st_r;
    bwe       = 1'b0;
    bwa       = fill_r;
    bwd       = dbyte;
    ctl       = '0;
    ctl.round = rnd_r;
    do_absorb = acc && op == sha256_pkg::OP_ABSORB && !fin_r;
    do_fin    = acc && op == sha256_pkg::OP_FINISH;
    case (st_r)
      S_IDLE: begin
        if (do_absorb) begin
          bwe = 1'b1;
          if (fill_r == AW'(BlockBytes - 1)) st_nxt = S_LOAD;
        end else if (do_fin) begin
          st_nxt = fin_r ? S_EMIT : S_PADB;
        end
      end
      S_PADB: begin
        bwe = 1'b1;
        bwa = padp_r[AW-1:0];
        if (first_pad_r && padp_r[AW-1:0] == fill_r) bwd = sha256_pkg::PAD_BYTE;
        else if (len_here_r && padp_r >= 7'd56) bwd = padbyte;
        else bwd = 8'h00;
        if (padp_r == 7'd63) st_nxt = S_LOAD;
      end
      S_LOAD: begin
        ctl.load = 1'b1;
        st_nxt   = S_FETCH;
      end
      S_FETCH: begin
        if (bsel_r == 2'd3) st_nxt = S_RND;
      end
      S_RND: begin
        ctl.step = 1'b1;
        if (rnd_r == 6'd15) st_nxt = S_RNDX;
        else st_nxt = S_FETCH;
      end
      S_RNDX: begin
        ctl.step = 1'b1;
        if (rnd_r == 6'd63) st_nxt = S_FOLD;
      end
      S_FOLD: begin
        ctl.fold = 1'b1;
        if (pad_r && second_r) st_nxt = S_PADB;
        else if (pad_r) st_nxt = S_EMIT;
        else st_nxt = S_IDLE;
      end
      S_EMIT: begin
        if (out_free && eidx_r == 4'd9) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // byte read address: prime at load, then advance on each fetch cycle but the last of a word, and on each round
  logic [AW-1:0] rda;
  assign rda = (st_r == S_LOAD) ? '0 : rda_r;

  sha256_buf #(.Depth(BlockBytes)) u_buf (
    .clk(clk), .wr_en(bwe), .wr_addr(bwa), .wr_data(bwd),
    .rd_addr(rda), .rd_data(brd)
  );

  logic restart;
  assign restart = acc && op == sha256_pkg::OP_RESTART;

  // chaining read address; held on the pending word while the output stalls
  logic [2:0] eprev_r;
  logic [2:0] hra;
  assign hra = (st_r == S_EMIT && !out_free) ? eprev_r : eidx_r[2:0];

  sha256_core u_core (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .wr_word(word_r),
    .init(restart), .hrd_addr(hra), .hrd_data(hrd), .fold_done(fdone)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      st_r <= S_IDLE; fill_r <= '0; bits_r <= '0; fin_r <= 1'b0;
      pad_r <= 1'b0; second_r <= 1'b0; padp_r <= '0; rnd_r <= '0;
      bsel_r <= '0; rda_r <= '0; eidx_r <= '0;
      first_pad_r <= 1'b0; len_here_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        S_IDLE: begin
          if (do_absorb) begin
            fill_r <= fill_r + 1'b1;
            bits_r <= bits_r + 64'd8;
          end else if (do_fin && !fin_r) begin
            pad_r       <= 1'b1;
            first_pad_r <= 1'b1;
            padp_r      <= {1'b0, fill_r};
            second_r    <= (fill_r >= AW'(56));
            len_here_r  <= (fill_r < AW'(56));
          end
          eidx_r <= '0;
          rnd_r  <= '0;
          bsel_r <= '0;
        end
        S_PADB: begin
          if (padp_r[AW-1:0] == fill_r) first_pad_r <= 1'b0;
          padp_r <= padp_r + 7'd1;
        end
        S_LOAD: begin
          rda_r  <= AW'(1);
          bsel_r <= '0;
          rnd_r  <= '0;
        end
        S_FETCH: begin
          word_r <= {word_r[23:0], brd};
          bsel_r <= bsel_r + 2'd1;
          if (bsel_r != 2'd3) rda_r <= rda_r + 1'b1;
        end
        S_RND: begin
          rnd_r  <= rnd_r + 6'd1;
          rda_r  <= rda_r + 1'b1;
          bsel_r <= '0;
        end
        S_RNDX: rnd_r <= rnd_r + 6'd1;
        S_FOLD: begin
          fill_r <= '0;
          if (pad_r && second_r) begin
            second_r    <= 1'b0;
            len_here_r  <= 1'b1;
            first_pad_r <= 1'b0;
            padp_r      <= '0;
          end
        end
        S_EMIT: begin
          pad_r <= 1'b0;
          fin_r <= 1'b1;
          if (out_free) eidx_r <= eidx_r + 4'd1;
        end
        default: ;
      endcase
    end
  end

  // Emission: eidx 0 issues a read; words leave at eidx 1..8 (read of
  // eidx-1 data). A read issued at eidx k returns at k+1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (out_free) begin
      ovalid_r <= 1'b0;
      if (st_r == S_EMIT && eidx_r >= 4'd1 && eidx_r <= 4'd8) begin
        ovalid_r <= 1'b1;
        oword_r  <= hrd;
        oidx_r   <= eprev_r;
        olast_r  <= (eprev_r == 3'd7);
        oerr_r   <= 1'b0;
      end else if (acc && op == sha256_pkg::OP_ABSORB && fin_r) begin
        ovalid_r <= 1'b1;
        oword_r  <= '0;
        oidx_r   <= '0;
        olast_r  <= 1'b0;
        oerr_r   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_EMIT && out_free) eprev_r <= eidx_r[2:0];
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'd0, oidx_r, oword_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = oerr_r;

  // fold_done is raised only in the cycle after the fold state
  assert property (@(posedge clk) disable iff (!rst_n)
    fdone |-> $past(st_r) == S_FOLD)
    else $error("fold flag without fold state");

  // no input taken outside the idle state
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_tready)
    else $error("input accepted while busy");

  // an error item never carries last
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tlast)
    else $error("error item marked last");

endmodule
`default_nettype wire

// ===== tb/sha256_stream_hasher_unit_chk.sv =====
// Checker for the SHA-256 stream hasher: watches the input and result channels,
// predicts digest and error items, and compares. Depends on sha256_pkg for op codes.
`timescale 1ns / 100ps
module sha256_stream_hasher_unit_chk (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [15:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  input  wire logic        out_tlast,
  input  wire logic        out_tuser,
  output int               fail_count,
  output int               pending_words
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
    logic        err;
  } digest_item_t;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] IV_TAB [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
    32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam int unsigned ExpDepth = 64;

  // predictor state
  logic [31:0]  hash_st [8];
  logic [7:0]   blk_bytes [128];
  int unsigned  fill_cnt;
  logic [63:0]  bit_len;
  logic         done_flag;
  digest_item_t exp_mem [ExpDepth];
  int unsigned  exp_wr;
  int unsigned  exp_rd;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // expected-item ring
  task automatic exp_put(digest_item_t it);
    exp_mem[exp_wr % ExpDepth] = it;
    exp_wr++;
  endtask

  // one compression over blk_bytes[base +: 64]
  task automatic run_block(int base);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[base+4*i], blk_bytes[base+4*i+1], blk_bytes[base+4*i+2],
              blk_bytes[base+4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] += v[i];
  endtask

  task automatic clear_state();
    for (int i = 0; i < 8; i++) hash_st[i] = IV_TAB[i];
    fill_cnt = 0;
    bit_len = '0;
    done_flag = 1'b0;
  endtask

  // padding: 0x80, zeros, big-endian bit length; one or two blocks
  task automatic close_message();
    int n;
    n = fill_cnt;
    for (int i = n; i < 128; i++) blk_bytes[i] = 8'h00;
    blk_bytes[n] = sha256_pkg::PAD_BYTE;
    n = (n + 1 <= 56) ? 56 : 120;
    for (int i = 0; i < 8; i++) blk_bytes[n+i] = bit_len[63-8*i -: 8];
    run_block(0);
    if (n == 120) run_block(64);
    fill_cnt = 0;
  endtask

  task automatic predict_item(logic [1:0] op, logic [7:0] b);
    case (op)
      sha256_pkg::OP_ABSORB: begin
        if (done_flag) begin
          exp_put('{word: '0, idx: '0, last: 1'b0, err: 1'b1});
        end else begin
          blk_bytes[fill_cnt] = b;
          bit_len += 64'd8;
          fill_cnt++;
          if (fill_cnt == 64) begin
            run_block(0);
            fill_cnt = 0;
          end
        end
      end
      sha256_pkg::OP_FINISH: begin
        if (!done_flag) begin
          close_message();
          done_flag = 1'b1;
        end
        for (int i = 0; i < 8; i++)
          exp_put('{word: hash_st[i], idx: 3'(i), last: (i == 7), err: 1'b0});
      end
      sha256_pkg::OP_RESTART: clear_state();
      default: ;
    endcase
  endtask

  assign pending_words = int'(exp_wr - exp_rd);

  always @(posedge clk) begin
    digest_item_t exp_item;
    if (!rst_n) begin
      clear_state();
      exp_wr = 0;
      exp_rd = 0;
      fail_count = 0;
    end else begin
      // result side first: predictions made this edge can't match this edge's output
      if (out_tvalid && out_tready) begin
        if (exp_wr == exp_rd) begin
          $error("unexpected result item: digest_word=%h", out_tdata[31:0]);
          fail_count++;
        end else begin
          exp_item = exp_mem[exp_rd % ExpDepth];
          exp_rd++;
          if (out_tdata[31:0] !== exp_item.word) begin
            $error("digest_word expected %h actual %h", exp_item.word, out_tdata[31:0]);
            fail_count++;
          end
          if (out_tdata[34:32] !== exp_item.idx) begin
            $error("word_index expected %0d actual %0d", exp_item.idx, out_tdata[34:32]);
            fail_count++;
          end
          if (out_tlast !== exp_item.last) begin
            $error("last expected %b actual %b", exp_item.last, out_tlast);
            fail_count++;
          end
          if (out_tuser !== exp_item.err) begin
            $error("error expected %b actual %b", exp_item.err, out_tuser);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) predict_item(in_tdata[1:0], in_tdata[9:2]);
    end
  end
endmodule

// ===== tb/sha256_stream_hasher_unit_tb.sv =====
// Testbench top for the SHA-256 stream hasher: clock, reset, stimulus and verdict.
// Depends on sha256_pkg, the hasher RTL and sha256_stream_hasher_unit_chk.
`timescale 1ns / 100ps
module sha256_stream_hasher_unit_tb;

  localparam int IdleLimit = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  int          fail_count;
  int          pending_words;
  int          idle_cycles = 0;
  int          item_total = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sha256_stream_hasher_unit dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser
  );

  sha256_stream_hasher_unit_chk chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser,
    .fail_count, .pending_words
  );

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stall per item, stretches of none
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      out_tready <= 1'b0;
      repeat (gap) @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      @(negedge clk);
    end
  end

  // one item with a random gap before it; valid held until accepted
  task automatic send_item(logic [1:0] op, logic [7:0] b, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, b, op};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    item_total++;
  endtask

  // a message of given length, then finish (sometimes repeated), sometimes a byte after it, and a restart
  task automatic send_message(int len);
    bit burst;
    burst = $urandom_range(0, 2) == 0;
    for (int i = 0; i < len; i++) send_item(sha256_pkg::OP_ABSORB, 8'($urandom), burst);
    send_item(sha256_pkg::OP_FINISH, 8'($urandom));
    if ($urandom_range(0, 3) == 0) send_item(sha256_pkg::OP_FINISH, 8'($urandom));
    if ($urandom_range(0, 3) == 0) send_item(sha256_pkg::OP_ABSORB, 8'($urandom));
    send_item(sha256_pkg::OP_RESTART, 8'($urandom));
  endtask

  initial begin
    int len;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty message, repeated finish, byte after finish, unused op
    send_item(sha256_pkg::OP_FINISH, 8'h00);
    send_item(sha256_pkg::OP_FINISH, 8'hff);
    send_item(sha256_pkg::OP_ABSORB, 8'hff);
    send_item(sha256_pkg::OP_UNUSED, 8'h55);
    send_item(sha256_pkg::OP_RESTART, 8'h00);
    // "abc", extreme bytes, ignored unused op mid-message
    send_item(sha256_pkg::OP_ABSORB, 8'h61);
    send_item(sha256_pkg::OP_ABSORB, 8'h62);
    send_item(sha256_pkg::OP_UNUSED, 8'hff);
    send_item(sha256_pkg::OP_ABSORB, 8'h63);
    send_item(sha256_pkg::OP_ABSORB, 8'h00);
    send_item(sha256_pkg::OP_ABSORB, 8'hff);
    send_item(sha256_pkg::OP_ABSORB, 8'haa);
    send_item(sha256_pkg::OP_ABSORB, 8'h55);
    send_item(sha256_pkg::OP_FINISH, 8'h00);
    send_item(sha256_pkg::OP_ABSORB, 8'h00);
    send_item(sha256_pkg::OP_RESTART, 8'hff);

    // random messages around the one- and two-block padding boundaries
    while (item_total < 380) begin
      case ($urandom_range(0, 5))
        0: len = $urandom_range(0, 8);
        1: len = $urandom_range(54, 57);
        2: len = $urandom_range(62, 66);
        3: len = $urandom_range(118, 122);
        default: len = $urandom_range(0, 40);
      endcase
      send_message(len);
      // occasional noise: restart mid-message or stray ops
      if ($urandom_range(0, 4) == 0) begin
        send_item(sha256_pkg::OP_ABSORB, 8'($urandom));
        send_item(2'($urandom_range(2, 3)), 8'($urandom));
      end
    end
    // final message of 56 bytes, which needs a second pad block
    send_message(56);
    in_tvalid <= 1'b0;

    while (pending_words != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
